// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sorted insertion buffer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SIB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define SIB_ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sib_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted insertion buffer package
// Types and constants shared by the cell chain, the controller and the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sib_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 16;
    localparam int M_USER_W  = 2;

    // Bit positions in the result tuser.
    localparam int M_USER_EMPTY = 0;
    localparam int M_USER_OVF   = 1;

    // Input item kinds carried on s_tuser.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DRAIN  = 1'b1;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;    // place the new value, shifting larger values up
        logic shift;  // move every entry one place towards the head
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/sorted_insertion_buffer.sv -----
// ----------------------------------------------------------------------------
// Sorted insertion buffer
// Insert: one transfer per cycle outside a drain, stored in the chain on accept.
// Drain: the drain transfer puts the controller in its drain state; results then
// leave the registered output one per cycle while m_tready is high, and s_tready
// stays low until the last result (flagged was_empty if none were stored) is loaded.
// Reset clears the valid bits, the controller state, the overflow flag and
// m_tvalid; the stored values themselves are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sorted_insertion_buffer #(
    parameter int DEPTH = sib_pkg::DEPTH_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // Input channel.
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [sib_pkg::DATA_W-1:0]       s_tdata,   // [31:0] value
    input  wire                              s_tuser,   // [0] kind
    // Result channel.
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [sib_pkg::DATA_W-1:0]       m_tdata,   // [31:0] sorted_value
    output logic                             m_tlast,
    output logic [sib_pkg::M_USER_W-1:0]     m_tuser    // [0] was_empty, [1] overflowed
);

    // The buffer is a row of DEPTH cells, cell 0 holding the smallest value.
    // Valid cells always form a contiguous run starting at cell 0, so the
    // number of stored values is implied and the buffer is full exactly when
    // the top cell is valid.
    //
    // On an insert every cell compares its value with the new one in
    // parallel. A cell whose lower neighbour is larger than the new value
    // takes that neighbour's value (the shift up); the first cell that is
    // larger than the new value, or the first free cell, takes the new value.
    // The compare is strict, so equal values stay in arrival order.
    //
    // On a drain the controller reads cell 0 into the output register and
    // the whole chain moves one place towards the head in the same cycle,
    // once per result transfer slot.

    sib_pkg::word_t      cell_val [DEPTH];
    logic [DEPTH-1:0]    cell_vld;
    logic [DEPTH-1:0]    cell_gt;
    sib_pkg::cell_ctrl_t cell_ctrl;
    sib_pkg::word_t      new_value;

    assign new_value = sib_pkg::word_t'(s_tdata);

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        sib_pkg::word_t lo_value;
        logic           lo_valid;
        logic           lo_gt;
        sib_pkg::word_t up_value;
        logic           up_valid;

        if (gi == 0) begin : g_head
            // A virtual valid entry, never larger than the new value, sits below the head.
            assign lo_value = '0;
            assign lo_valid = 1'b1;
            assign lo_gt    = 1'b0;
        end else begin : g_body
            assign lo_value = cell_val[gi-1];
            assign lo_valid = cell_vld[gi-1];
            assign lo_gt    = cell_gt[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign up_value = '0;
            assign up_valid = 1'b0;
        end else begin : g_inner
            assign up_value = cell_val[gi+1];
            assign up_valid = cell_vld[gi+1];
        end

        sib_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .new_value (new_value),
            .lo_value  (lo_value),
            .lo_valid  (lo_valid),
            .lo_gt     (lo_gt),
            .up_value  (up_value),
            .up_valid  (up_valid),
            .value     (cell_val[gi]),
            .valid     (cell_vld[gi]),
            .gt        (cell_gt[gi])
        );
    end

    // The controller owns the handshakes, the overflow flag and the result
    // register that decouples the chain from the result channel.
    sib_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_kind     (s_tuser),
        .full       (cell_vld[DEPTH-1]),
        .head_value (cell_val[0]),
        .head_valid (cell_vld[0]),
        .next_valid (cell_vld[1]),
        .cell_ctrl  (cell_ctrl),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // Valid cells must stay a contiguous run from the head.
    `SIB_ASSERT(a_vld_contig, aclk, aresetn, (cell_vld & (cell_vld + 1'b1)) == '0, "valid cells not contiguous")
    // The valid bits of a full buffer must not change on an insert.
    `SIB_ASSERT_NEXT(a_full_hold, aclk, aresetn, s_tvalid && s_tready && (s_tuser == sib_pkg::KIND_INSERT) && cell_vld[DEPTH-1], $stable(cell_vld), "full buffer changed on insert")

endmodule

`default_nettype wire

// ----- rtl/sib_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted insertion buffer cell
// One stored entry with its valid bit and the compare against a new value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sib_cell (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  sib_pkg::cell_ctrl_t ctrl,
    input  sib_pkg::word_t      new_value,
    input  sib_pkg::word_t      lo_value,
    input  wire                 lo_valid,
    input  wire                 lo_gt,
    input  sib_pkg::word_t      up_value,
    input  wire                 up_valid,
    output sib_pkg::word_t      value,
    output logic                valid,
    output logic                gt
);

    sib_pkg::word_t value_reg;
    sib_pkg::word_t value_next;
    logic           valid_reg;
    logic           valid_next;

    assign gt = valid_reg && (value_reg > new_value);

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift) begin
            value_next = up_value;
            valid_next = up_valid;
        end else if (ctrl.ins) begin
            if (lo_gt) begin
                // The neighbour below is larger than the new value and moves up.
                value_next = lo_value;
                valid_next = 1'b1;
            end else if (lo_valid && (gt || !valid_reg)) begin
                // First place whose stored value is larger, or the first free place.
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// ----- rtl/sib_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sorted insertion buffer controller
// Input handshake, drain sequencing, overflow flag and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sib_ctrl (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire                              s_kind,
    input  wire                              full,
    input  sib_pkg::word_t                   head_value,
    input  wire                              head_valid,
    input  wire                              next_valid,
    output sib_pkg::cell_ctrl_t              cell_ctrl,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [sib_pkg::DATA_W-1:0]       m_tdata,
    output logic                             m_tlast,
    output logic [sib_pkg::M_USER_W-1:0]     m_tuser
);

    sib_pkg::state_t state_reg;
    sib_pkg::state_t state_next;

    logic           ovf_reg;
    logic           ovf_next;
    logic           m_tvalid_reg;
    logic           m_tvalid_next;
    sib_pkg::word_t m_data_reg;
    logic           m_last_reg;
    logic           m_empty_reg;
    logic           m_ovf_reg;

    logic load;
    logic emit_last;
    logic ins_drop;

    assign emit_last = !head_valid || !next_valid;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sib_pkg::ST_IDLE: begin
                if (s_tvalid && (s_kind == sib_pkg::KIND_DRAIN)) begin
                    state_next = sib_pkg::ST_DRAIN;
                end
            end
            sib_pkg::ST_DRAIN: begin
                if (load && emit_last) begin
                    state_next = sib_pkg::ST_IDLE;
                end
            end
            default: state_next = sib_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready        = 1'b0;
        cell_ctrl.ins   = 1'b0;
        cell_ctrl.shift = 1'b0;
        load            = 1'b0;
        ins_drop        = 1'b0;
        unique case (state_reg)
            sib_pkg::ST_IDLE: begin
                s_tready      = 1'b1;
                cell_ctrl.ins = s_tvalid && (s_kind == sib_pkg::KIND_INSERT) && !full;
                ins_drop      = s_tvalid && (s_kind == sib_pkg::KIND_INSERT) && full;
            end
            sib_pkg::ST_DRAIN: begin
                load            = !m_tvalid_reg || m_tready;
                cell_ctrl.shift = load;
            end
            default: ;
        endcase
    end

    always_comb begin
        ovf_next = ovf_reg;
        if (ins_drop) begin
            ovf_next = 1'b1;
        end else if (load && emit_last) begin
            ovf_next = 1'b0;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sib_pkg::ST_IDLE;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg  <= head_valid ? head_value : '0;
            m_last_reg  <= emit_last;
            m_empty_reg <= !head_valid;
            m_ovf_reg   <= ovf_reg;
        end
    end

    assign m_tvalid                     = m_tvalid_reg;
    assign m_tdata                      = m_data_reg;
    assign m_tlast                      = m_last_reg;
    assign m_tuser[sib_pkg::M_USER_EMPTY] = m_empty_reg;
    assign m_tuser[sib_pkg::M_USER_OVF]   = m_ovf_reg;

    `SIB_ASSERT(a_ins_shift_excl, aclk, aresetn, !(cell_ctrl.ins && cell_ctrl.shift), "insert and shift issued together")
    `SIB_ASSERT_NEXT(a_ovf_cleared, aclk, aresetn, load && emit_last && !ins_drop, !ovf_reg, "overflow flag not cleared by drain")
    `SIB_ASSERT(a_empty_result, aclk, aresetn, (m_tvalid_reg && m_empty_reg) |-> (m_last_reg && (m_data_reg == '0)), "empty result malformed")
    `SIB_ASSERT_NEXT(a_drain_busy, aclk, aresetn, s_tvalid && s_tready && (s_kind == sib_pkg::KIND_DRAIN), !s_tready, "input taken during drain")

endmodule

`default_nettype wire
